// ----- sv/psc_pkg.sv -----
// Shared types and constants for the polyline scanline crossing block.
`default_nettype none
package psc_pkg;
  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_START  = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned TOL_W   = 16;
  localparam int unsigned IDX_W   = 6;

  // Datapath operation selects, driven by the controller.
  typedef enum logic [3:0] {
    OP_NONE     = 4'd0,
    OP_LOAD     = 4'd1,
    OP_QSETUP   = 4'd2,
    OP_RD_I     = 4'd3,
    OP_RD_J     = 4'd4,
    OP_CAP_I    = 4'd5,
    OP_CAP_J    = 4'd6,
    OP_STEP_J   = 4'd7,
    OP_MUL      = 4'd8,
    OP_DIV_INIT = 4'd9,
    OP_DIV_STEP = 4'd10,
    OP_FINISH   = 4'd11,
    OP_NEXT_I   = 4'd12,
    OP_EMPTY    = 4'd13
  } op_t;

  typedef struct packed {
    op_t  op;
    logic out_load;
  } ctl_t;

  typedef struct packed {
    logic more_i;
    logic crosses;
    logic flat;
    logic walk_done;
    logic div_done;
    logic any;
  } sts_t;
endpackage
`default_nettype wire

// ----- sv/psc_if.sv -----
// Valid/ready channel interfaces for input items and results.
`default_nettype none
interface psc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic signed [31:0] vertex_u;
  logic signed [31:0] vertex_v;
  logic signed [31:0] line_value;
  logic        line_axis;
  modport source (output valid, command, vertex_u, vertex_v, line_value, line_axis,
                  input ready);
  modport sink (input valid, command, vertex_u, vertex_v, line_value, line_axis,
                output ready);
endinterface

interface psc_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] cross_u;
  logic signed [31:0] cross_v;
  logic        point_valid;
  logic        last_of_run;
  logic [5:0]  crossing_index;
  modport source (output valid, cross_u, cross_v, point_valid, last_of_run,
                  crossing_index, input ready);
  modport sink (input valid, cross_u, cross_v, point_valid, last_of_run,
                crossing_index, output ready);
endinterface
`default_nettype wire

// ----- sv/polyline_scanline_crossings.sv -----
// Polyline scanline crossings: top level joining controller and datapath.
`default_nettype none
// Loads a closed polyline (command 0 append, 1 restart) one vertex per cycle while idle and
// answers a crossing query (command 2) with one result per crossing, in vertex order, the
// last flagged, or one invalid result when there is none. A query visits each vertex in
// turn, walks back over flat edges and runs the 64-step restoring divider once per crossing;
// up to MAX_VERTS vertices are held in one memory. Only one item is in work at a time.
module polyline_scanline_crossings #(
  parameter int unsigned MAX_VERTS = 64
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  psc_in_if.sink     in_ch,
  psc_out_if.source  out_ch,
  input  wire logic  cfg_we,
  input  wire logic [15:0] cfg_wdata
);
  psc_pkg::ctl_t ctl;
  psc_pkg::sts_t sts;
  logic [15:0] tol_r;
  logic out_busy;

  always_ff @(posedge clk) begin
    if (!rst_n) tol_r <= 16'd1;
    else if (cfg_we) tol_r <= cfg_wdata;
  end

  assign out_busy = out_ch.valid && !out_ch.ready;

  psc_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_cmd(in_ch.command), .in_ready(in_ch.ready),
    .out_busy, .sts, .ctl
  );

  psc_dp #(.MAX_VERTS(MAX_VERTS)) u_dp (
    .clk, .rst_n, .ctl,
    .in_cmd(in_ch.command), .in_u(in_ch.vertex_u), .in_v(in_ch.vertex_v),
    .in_line(in_ch.line_value), .in_axis(in_ch.line_axis), .tol(tol_r), .sts,
    .out_ready(out_ch.ready), .out_valid(out_ch.valid), .out_u(out_ch.cross_u),
    .out_v(out_ch.cross_v), .out_pv(out_ch.point_valid), .out_last(out_ch.last_of_run),
    .out_idx(out_ch.crossing_index)
  );

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.command == psc_pkg::CMD_QUERY) |=> !in_ch.ready)
    else $error("query accepted without leaving idle");
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.point_valid) |-> out_ch.last_of_run)
    else $error("invalid result not marked last");
`endif
endmodule
`default_nettype wire

// ----- sv/psc_ctrl.sv -----
// Controller state machine sequencing loads and crossing queries.
`default_nettype none
module psc_ctrl (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic [1:0]  in_cmd,
  output logic             in_ready,
  input  wire logic        out_busy,
  input  wire psc_pkg::sts_t sts,
  output psc_pkg::ctl_t    ctl
);
  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_RDI   = 12'b000000000010,
    S_CAPI  = 12'b000000000100,
    S_RDJ   = 12'b000000001000,
    S_CAPJ  = 12'b000000010000,
    S_TEST  = 12'b000000100000,
    S_MUL   = 12'b000001000000,
    S_DINIT = 12'b000010000000,
    S_DIV   = 12'b000100000000,
    S_EMIT  = 12'b001000000000,
    S_NEXT  = 12'b010000000000,
    S_END   = 12'b100000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   walk_r, walk_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      walk_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      walk_r  <= walk_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    walk_nxt     = walk_r;
    ctl.op       = psc_pkg::OP_NONE;
    ctl.out_load = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_cmd == psc_pkg::CMD_LOAD || in_cmd == psc_pkg::CMD_START) begin
            ctl.op = psc_pkg::OP_LOAD;
          end else if (in_cmd == psc_pkg::CMD_QUERY) begin
            ctl.op    = psc_pkg::OP_QSETUP;
            state_nxt = S_NEXT;
          end
        end
      end
      S_NEXT: begin
        // decide whether another vertex i remains
        if (sts.more_i) begin
          ctl.op    = psc_pkg::OP_RD_I;
          state_nxt = S_CAPI;
        end else begin
          state_nxt = S_END;
        end
      end
      S_RDI: state_nxt = S_CAPI;
      S_CAPI: begin
        ctl.op    = psc_pkg::OP_CAP_I;
        walk_nxt  = 1'b0;
        state_nxt = S_RDJ;
      end
      S_RDJ: begin
        ctl.op    = psc_pkg::OP_RD_J;
        state_nxt = S_CAPJ;
      end
      S_CAPJ: begin
        ctl.op    = psc_pkg::OP_CAP_J;
        state_nxt = S_TEST;
      end
      S_TEST: begin
        // the crossing test applies to the direct predecessor only
        if (!walk_r && !sts.crosses) begin
          ctl.op    = psc_pkg::OP_NEXT_I;
          state_nxt = S_NEXT;
        end else if (sts.flat && !sts.walk_done) begin
          ctl.op    = psc_pkg::OP_STEP_J;
          walk_nxt  = 1'b1;
          state_nxt = S_RDJ;
        end else begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        ctl.op    = psc_pkg::OP_MUL;
        state_nxt = S_DINIT;
      end
      S_DINIT: begin
        ctl.op    = psc_pkg::OP_DIV_INIT;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_nxt = S_EMIT;
        end else begin
          ctl.op = psc_pkg::OP_DIV_STEP;
        end
      end
      S_EMIT: begin
        // hold the finished point until the result register frees up
        if (!out_busy) begin
          ctl.op    = psc_pkg::OP_FINISH;
          state_nxt = S_NEXT;
        end
      end
      S_END: begin
        if (!out_busy) begin
          ctl.op       = sts.any ? psc_pkg::OP_FINISH : psc_pkg::OP_EMPTY;
          ctl.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ----- sv/psc_dp.sv -----
// Datapath: vertex memory, crossing test, flat walk, product and serial divider.
`default_nettype none
module psc_dp #(
  parameter int unsigned MAX_VERTS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire psc_pkg::ctl_t ctl,
  input  wire logic [1:0]  in_cmd,
  input  wire logic signed [31:0] in_u,
  input  wire logic signed [31:0] in_v,
  input  wire logic signed [31:0] in_line,
  input  wire logic        in_axis,
  input  wire logic [15:0] tol,
  output psc_pkg::sts_t    sts,
  input  wire logic        out_ready,
  output logic             out_valid,
  output logic signed [31:0] out_u,
  output logic signed [31:0] out_v,
  output logic             out_pv,
  output logic             out_last,
  output logic [5:0]       out_idx
);
  localparam int unsigned AW = $clog2(MAX_VERTS);
  localparam int unsigned CW = $clog2(MAX_VERTS + 1);

  logic [63:0] mem_r [MAX_VERTS];
  logic [63:0] rd_r;
  logic [CW-1:0] total_r;
  logic [AW-1:0] i_r, j_r, last_r;
  logic [CW-1:0] steps_r;
  logic [AW-1:0] rd_addr;
  logic signed [31:0] line_r;
  logic axis_r;
  logic signed [31:0] ki_r, mi_r, kj_r, mj_r;
  logic [63:0] prod_r;
  logic [33:0] dmag_r;
  logic neg_r, dz_r;
  logic [63:0] quo_r;
  logic [34:0] rem_r;
  logic [6:0] dcnt_r;
  logic [5:0] cnt_r;
  // pending point waits here until the next one is known or the run ends
  logic        pend_r;
  logic signed [31:0] pu_r, pv_r;
  logic [5:0]  pidx_r;

  logic signed [32:0] dk, a33, b33, d33;
  logic [32:0] amag, bmag;
  logic [34:0] rem_sh;
  logic signed [34:0] sum;
  logic signed [31:0] other;
  logic [AW-1:0] jprev;
  logic [CW-1:0] np1;
  logic out_set;

  assign np1 = (total_r != '0) ? total_r - CW'(1) : '0;
  assign rd_addr = (ctl.op == psc_pkg::OP_RD_I) ? i_r : j_r;
  assign jprev = (j_r == '0) ? last_r : j_r - AW'(1);
  assign out_set = (ctl.op == psc_pkg::OP_FINISH && (ctl.out_load || pend_r)) ||
                   (ctl.op == psc_pkg::OP_EMPTY);

  always_ff @(posedge clk) begin
    if (ctl.op == psc_pkg::OP_LOAD) begin
      if (in_cmd == psc_pkg::CMD_START) begin
        mem_r[0] <= {in_u, in_v};
      end else if (total_r < CW'(MAX_VERTS)) begin
        mem_r[total_r[AW-1:0]] <= {in_u, in_v};
      end
    end
    rd_r <= mem_r[rd_addr];
  end

  // split an entry into axis and other coordinate
  logic signed [31:0] rk, rm;
  assign rk = axis_r ? rd_r[63:32] : rd_r[31:0];
  assign rm = axis_r ? rd_r[31:0] : rd_r[63:32];

  assign dk   = 33'(kj_r) - 33'(ki_r);
  assign a33  = 33'(line_r) - 33'(ki_r);
  assign b33  = 33'(mj_r) - 33'(mi_r);
  assign d33  = dk;
  assign amag = a33[32] ? 33'(-a33) : 33'(a33);
  assign bmag = b33[32] ? 33'(-b33) : 33'(b33);

  assign rem_sh = {rem_r[33:0], quo_r[63]};
  assign sum = neg_r ? 35'(mi_r) - 35'(quo_r[33:0]) : 35'(mi_r) + 35'(quo_r[33:0]);

  always_comb begin
    if (dz_r) other = mi_r;
    else if (quo_r[63:33] != '0) other = neg_r ? 32'sh80000000 : 32'sh7fffffff;
    else if (sum > 35'sd2147483647) other = 32'sh7fffffff;
    else if (sum < -35'sd2147483648) other = 32'sh80000000;
    else other = sum[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
      pend_r <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && !out_set) out_valid <= 1'b0;
      unique case (ctl.op)
        psc_pkg::OP_LOAD: begin
          if (in_cmd == psc_pkg::CMD_START) total_r <= CW'(1);
          else if (total_r < CW'(MAX_VERTS)) total_r <= total_r + CW'(1);
        end
        psc_pkg::OP_QSETUP: begin
          line_r <= in_line; axis_r <= in_axis;
          i_r <= '0; cnt_r <= '0; pend_r <= 1'b0;
          last_r <= (np1 >= CW'(1)) ? AW'(np1 - CW'(1)) : AW'(MAX_VERTS - 1);
        end
        psc_pkg::OP_CAP_I: begin
          ki_r <= rk; mi_r <= rm; steps_r <= '0;
          j_r <= (i_r == '0) ? last_r : i_r - AW'(1);
        end
        psc_pkg::OP_CAP_J: begin
          kj_r <= rk; mj_r <= rm;
        end
        psc_pkg::OP_STEP_J: begin
          j_r <= jprev; steps_r <= steps_r + CW'(1);
        end
        psc_pkg::OP_NEXT_I: i_r <= i_r + AW'(1);
        psc_pkg::OP_MUL: begin
          prod_r <= 64'(amag) * 64'(bmag);
          dmag_r <= 34'(d33[32] ? 33'(-d33) : 33'(d33));
          dz_r   <= (d33 == '0);
          neg_r  <= (a33 != '0 && b33 != '0) && ((a33[32] ^ b33[32]) ^ d33[32]);
        end
        psc_pkg::OP_DIV_INIT: begin
          quo_r <= prod_r; rem_r <= '0; dcnt_r <= '0;
        end
        psc_pkg::OP_DIV_STEP: begin
          // one restoring step per cycle
          if (rem_sh >= 35'(dmag_r)) begin
            rem_r <= rem_sh - 35'(dmag_r); quo_r <= {quo_r[62:0], 1'b1};
          end else begin
            rem_r <= rem_sh; quo_r <= {quo_r[62:0], 1'b0};
          end
          dcnt_r <= dcnt_r + 7'd1;
        end
        psc_pkg::OP_FINISH: begin
          if (ctl.out_load) begin
            out_valid <= 1'b1; out_u <= pu_r; out_v <= pv_r;
            out_pv <= 1'b1; out_last <= 1'b1; out_idx <= pidx_r;
            pend_r <= 1'b0;
          end else begin
            if (pend_r) begin
              out_valid <= 1'b1; out_u <= pu_r; out_v <= pv_r;
              out_pv <= 1'b1; out_last <= 1'b0; out_idx <= pidx_r;
            end
            pend_r <= 1'b1;
            pu_r <= axis_r ? line_r : other;
            pv_r <= axis_r ? other : line_r;
            pidx_r <= cnt_r;
            cnt_r <= cnt_r + 6'd1;
            i_r <= i_r + AW'(1);
          end
        end
        psc_pkg::OP_EMPTY: begin
          out_valid <= 1'b1; out_u <= '0; out_v <= '0;
          out_pv <= 1'b0; out_last <= 1'b1; out_idx <= '0;
        end
        default: ;
      endcase
    end
  end

  logic [32:0] dkmag;
  assign dkmag = dk[32] ? 33'(-dk) : 33'(dk);
  assign sts.more_i    = (CW'(i_r) < np1) && !(i_r == '0 && np1 == '0);
  assign sts.crosses   = (ki_r > line_r && kj_r <= line_r) || (ki_r < line_r && kj_r >= line_r);
  assign sts.flat      = (dkmag < 33'(tol));
  assign sts.walk_done = (steps_r >= total_r);
  assign sts.div_done  = (dcnt_r == 7'd64);
  assign sts.any       = pend_r;
endmodule
`default_nettype wire

// ----- tb/sv/psc_tb_if.sv -----
// Testbench interface bundling the configuration write port.
`timescale 1ns / 1ps
`default_nettype none
interface psc_tb_cfg_if;
  logic        we    = 1'b0;
  logic [15:0] wdata = '0;
endinterface
`default_nettype wire

// ----- tb/sv/tb_polyline_scanline_crossings.sv -----
// Self-checking testbench for polyline_scanline_crossings: directed table, then random.
`timescale 1ns / 1ps
module tb_polyline_scanline_crossings;
  localparam int NV = 64;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] vu;
    logic signed [31:0] vv;
    logic signed [31:0] line;
    logic               axis;
  } item_t;

  typedef struct packed {
    logic signed [31:0] cu;
    logic signed [31:0] cv;
    logic               pv;
    logic               last;
    logic [5:0]         idx;
  } xing_t;

  typedef struct packed {
    item_t it;
    logic  has_exp;
    xing_t exp;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  psc_in_if     in_ch ();
  psc_out_if    out_ch ();
  psc_tb_cfg_if cfg_bus ();

  polyline_scanline_crossings u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_bus.we), .cfg_wdata(cfg_bus.wdata)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [31:0] poly_u [NV];
  logic [31:0] poly_v [NV];
  int unsigned poly_cnt;
  logic [15:0] tol;

  xing_t pending_xings[$];
  int errors = 0;
  int n_checked = 0;
  int n_points = 0;
  int n_items = 0;
  bit rx_idle_en = 1'b1;
  bit tx_idle_en = 1'b1;
  bit hold_rx = 1'b0;

  function automatic logic [63:0] mag64(longint x);
    return x < 0 ? 64'(-x) : 64'(x);
  endfunction

  function automatic longint lerp_other(longint mi, longint mj, longint ki, longint kj,
                                        longint line);
    longint a, b, d, r;
    logic [127:0] prod;
    logic [127:0] q;
    bit neg;
    a = line - ki;
    b = mj - mi;
    d = kj - ki;
    if (d == 0) return mi;
    prod = 128'(mag64(a)) * 128'(mag64(b));
    q = prod / 128'(mag64(d));
    neg = ((a < 0) != (b < 0)) != (d < 0);
    if (a == 0 || b == 0) neg = 1'b0;
    if (q >= (128'd1 << 33)) return neg ? -64'sd2147483648 : 64'sd2147483647;
    r = neg ? mi - longint'(q[63:0]) : mi + longint'(q[63:0]);
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r;
  endfunction

  // Apply one item to the predictor; queue the crossings it yields.
  task automatic predict_crossings(input item_t it);
    int unsigned np1, i, j, steps, cnt;
    longint ki, kj, line, other;
    logic [31:0] kval_i, kval_j;
    xing_t x;
    cnt = 0;
    if (it.command == psc_pkg::CMD_LOAD || it.command == psc_pkg::CMD_START) begin
      if (it.command == psc_pkg::CMD_START) poly_cnt = 0;
      if (poly_cnt < NV) begin
        poly_u[poly_cnt] = it.vu;
        poly_v[poly_cnt] = it.vv;
        poly_cnt++;
      end
      return;
    end
    if (it.command != psc_pkg::CMD_QUERY) return;
    line = longint'(it.line);
    np1 = poly_cnt >= 1 ? poly_cnt - 1 : 0;
    for (i = 0; i < np1; i++) begin
      j = (i == 0) ? np1 - 1 : i - 1;
      kval_i = it.axis ? poly_u[i] : poly_v[i];
      kval_j = it.axis ? poly_u[j] : poly_v[j];
      ki = longint'($signed(kval_i));
      kj = longint'($signed(kval_j));
      if (!((ki > line && kj <= line) || (ki < line && kj >= line))) continue;
      steps = 0;
      while (steps < poly_cnt && mag64(kj - ki) < 64'(tol)) begin
        j = (j == 0) ? np1 - 1 : j - 1;
        kval_j = it.axis ? poly_u[j] : poly_v[j];
        kj = longint'($signed(kval_j));
        steps++;
      end
      if (it.axis)
        other = lerp_other(longint'($signed(poly_v[i])), longint'($signed(poly_v[j])),
                           ki, kj, line);
      else
        other = lerp_other(longint'($signed(poly_u[i])), longint'($signed(poly_u[j])),
                           ki, kj, line);
      x.cu = it.axis ? it.line : 32'(other);
      x.cv = it.axis ? 32'(other) : it.line;
      x.pv = 1'b1;
      x.last = 1'b0;
      x.idx = 6'(cnt);
      pending_xings.push_back(x);
      cnt++;
    end
    if (cnt == 0) begin
      x = '0;
      x.last = 1'b1;
      pending_xings.push_back(x);
    end else begin
      x = pending_xings.pop_back();
      x.last = 1'b1;
      pending_xings.push_back(x);
    end
  endtask

  // Result side: random stalls, long hold-off on request.
  initial begin
    int gap;
    out_ch.ready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      @(posedge clk);
      if (hold_rx) begin
        out_ch.ready <= 1'b0;
        repeat (3000) @(posedge clk);
        hold_rx = 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 12);
        out_ch.ready <= 1'b0;
        repeat (gap - 1) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Compare each transfer with the oldest expectation.
  always @(posedge clk) begin
    xing_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.cross_u, out_ch.cross_v, out_ch.point_valid, out_ch.last_of_run,
              out_ch.crossing_index};
      if (pending_xings.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        want = pending_xings.pop_front();
        n_checked++;
        if (got.pv) n_points++;
        if (got.cu !== want.cu)
          begin $display("%0t: cross_u exp %h got %h", $time, want.cu, got.cu); errors++; end
        if (got.cv !== want.cv)
          begin $display("%0t: cross_v exp %h got %h", $time, want.cv, got.cv); errors++; end
        if (got.pv !== want.pv)
          begin $display("%0t: point_valid exp %b got %b", $time, want.pv, got.pv); errors++; end
        if (got.last !== want.last)
          begin $display("%0t: last_of_run exp %b got %b", $time, want.last, got.last);
            errors++; end
        if (got.idx !== want.idx)
          begin $display("%0t: crossing_index exp %0d got %0d", $time, want.idx, got.idx);
            errors++; end
      end
    end
  end

  task automatic send_item(input item_t it);
    int gap;
    if (tx_idle_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 12);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.command  <= it.command;
    in_ch.vertex_u <= it.vu;
    in_ch.vertex_v <= it.vv;
    in_ch.line_value <= it.line;
    in_ch.line_axis  <= it.axis;
    @(posedge clk iff in_ch.ready);
    predict_crossings(it);
    n_items++;
  endtask

  task automatic go_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait (pending_xings.size() == 0);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_tol(input logic [15:0] v);
    cfg_bus.we <= 1'b1;
    cfg_bus.wdata <= v;
    @(posedge clk);
    cfg_bus.we <= 1'b0;
    tol = v;
  endtask

  function automatic item_t mk_vtx(logic [1:0] c, logic [31:0] u, logic [31:0] v);
    return '{c, u, v, $urandom(), 1'($urandom())};
  endfunction

  function automatic item_t mk_qry(logic [31:0] l, logic a);
    return '{psc_pkg::CMD_QUERY, $urandom(), $urandom(), l, a};
  endfunction

  function automatic logic [31:0] rnd_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
      default: return 32'($signed($urandom_range(0, 40)) - 20);
    endcase
  endfunction

  // Send a random closed polygon and a few queries across it.
  task automatic send_polygon(input int nv, input int mode);
    logic [31:0] fu, fv, l;
    item_t q;
    int k;
    fu = rnd_coord(mode);
    fv = rnd_coord(mode);
    send_item(mk_vtx(psc_pkg::CMD_START, fu, fv));
    for (k = 1; k < nv - 1; k++) begin
      // occasionally repeat the axis coordinate to force flat edges
      if ($urandom_range(0, 4) == 0)
        send_item(mk_vtx(psc_pkg::CMD_LOAD, rnd_coord(mode), fv));
      else
        send_item(mk_vtx(psc_pkg::CMD_LOAD, rnd_coord(mode), rnd_coord(mode)));
    end
    send_item(mk_vtx(psc_pkg::CMD_LOAD, fu, fv));
    repeat ($urandom_range(1, 4)) begin
      l = ($urandom_range(0, 3) == 0) ? fv : rnd_coord(mode);
      q = mk_qry(l, 1'($urandom()));
      send_item(q);
    end
  endtask

  row_t dir_rows[$];

  initial begin
    int k;
    in_ch.valid <= 1'b0;
    in_ch.command <= psc_pkg::CMD_LOAD;
    in_ch.vertex_u <= '0;
    in_ch.vertex_v <= '0;
    in_ch.line_value <= '0;
    in_ch.line_axis <= 1'b0;
    tol = 16'd1;
    poly_cnt = 0;
    foreach (poly_u[k]) begin poly_u[k] = '0; poly_v[k] = '0; end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table; fixed expectations only where obvious
    dir_rows.push_back('{mk_qry(32'sd0, 1'b0), 1'b1, '{32'd0, 32'd0, 1'b0, 1'b1, 6'd0}});
    dir_rows.push_back('{mk_vtx(psc_pkg::CMD_UNUSED, 32'h7fffffff, 32'h80000000), 1'b0, '0});
    dir_rows.push_back('{mk_vtx(psc_pkg::CMD_START, 32'h80000000, 32'h80000000), 1'b0, '0});
    dir_rows.push_back('{mk_qry(32'h7fffffff, 1'b1), 1'b1, '{32'd0, 32'd0, 1'b0, 1'b1, 6'd0}});
    dir_rows.push_back('{mk_vtx(psc_pkg::CMD_LOAD, 32'h7fffffff, 32'h80000000), 1'b0, '0});
    dir_rows.push_back('{mk_vtx(psc_pkg::CMD_LOAD, 32'h7fffffff, 32'h7fffffff), 1'b0, '0});
    dir_rows.push_back('{mk_vtx(psc_pkg::CMD_LOAD, 32'h80000000, 32'h7fffffff), 1'b0, '0});
    dir_rows.push_back('{mk_vtx(psc_pkg::CMD_LOAD, 32'h80000000, 32'h80000000), 1'b0, '0});
    dir_rows.push_back('{mk_qry(32'h00000000, 1'b0), 1'b0, '0});
    dir_rows.push_back('{mk_qry(32'h00000000, 1'b1), 1'b0, '0});
    dir_rows.push_back('{mk_qry(32'h7fffffff, 1'b0), 1'b0, '0});
    dir_rows.push_back('{mk_qry(32'h80000000, 1'b1), 1'b0, '0});
    dir_rows.push_back('{mk_qry(32'h7ffffffe, 1'b1), 1'b0, '0});
    dir_rows.push_back('{mk_qry(32'h12345678, 1'b0), 1'b0, '0});
    // steep edge: large numerator, tiny divisor
    dir_rows.push_back('{mk_vtx(psc_pkg::CMD_START, 32'h80000000, 32'h00000000), 1'b0, '0});
    dir_rows.push_back('{mk_vtx(psc_pkg::CMD_LOAD, 32'h7fffffff, 32'h00000002), 1'b0, '0});
    dir_rows.push_back('{mk_vtx(psc_pkg::CMD_LOAD, 32'h7fffffff, 32'hffffffff), 1'b0, '0});
    dir_rows.push_back('{mk_vtx(psc_pkg::CMD_LOAD, 32'h80000000, 32'h00000000), 1'b0, '0});
    dir_rows.push_back('{mk_qry(32'h00000001, 1'b0), 1'b0, '0});
    dir_rows.push_back('{mk_qry(32'h00000000, 1'b0), 1'b0, '0});
    dir_rows.push_back('{mk_qry(32'h00000000, 1'b1), 1'b0, '0});
    foreach (dir_rows[k]) begin
      send_item(dir_rows[k].it);
      if (dir_rows[k].has_exp && pending_xings.size() > 0 &&
          pending_xings[$] !== dir_rows[k].exp) begin
        $display("%0t: directed row %0d exp %h got %h", $time, k, dir_rows[k].exp,
                 pending_xings[$]);
        errors++;
      end
    end
    go_idle();

    // full store plus one ignored append, with all-flat walk
    write_tol(16'hffff);
    send_item(mk_vtx(psc_pkg::CMD_START, 32'd0, 32'd0));
    for (k = 1; k < NV + 1; k++) send_item(mk_vtx(psc_pkg::CMD_LOAD, 32'(k), 32'(k % 3)));
    send_item(mk_qry(32'sd1, 1'b0));
    send_item(mk_qry(32'sd5, 1'b1));
    // receiver holds off while queries keep coming
    hold_rx = 1'b1;
    repeat (6) send_item(mk_qry(32'($urandom_range(0, 3)), 1'($urandom())));
    go_idle();

    write_tol(16'd0);
    repeat (12) send_polygon($urandom_range(3, 10), $urandom_range(0, 2));
    go_idle();
    write_tol(16'($urandom()));
    repeat (8) send_polygon($urandom_range(3, 10), $urandom_range(0, 2));
    send_polygon(NV, 1);
    go_idle();
    write_tol(16'd1);
    rx_idle_en = 1'b0;
    tx_idle_en = 1'b0;
    while (n_items < 370) send_polygon($urandom_range(3, 8), $urandom_range(0, 2));
    in_ch.valid <= 1'b0;
    wait (pending_xings.size() == 0);
    repeat (300) @(posedge clk);

    $display("Sent %0d items; checked %0d results, %0d of them crossings.",
             n_items, n_checked, n_points);
    if (errors == 0)
      $display("polyline_scanline_crossings regression: pass");
    else
      $display("polyline_scanline_crossings regression: fail");
    $finish;
  end

  initial begin
    #60ms;
    $display("polyline_scanline_crossings regression: fail");
    $finish;
  end
endmodule
